// ===== src/hsl2rgb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and constant-divide helpers for the hue/saturation/level to rgb converter
// no dependencies

package hsl2rgb_pkg;

  // scale limits
  localparam logic [7:0]  HS_FULL  = 8'd254;
  localparam logic [7:0]  CH_FULL  = 8'd255;
  localparam logic [15:0] HS_SQ    = 16'd64516;   // 254 * 254
  localparam logic [2:0]  SECTORS  = 3'd6;

  // sector codes
  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  // reciprocals for quotient by multiply and shift right 32
  // exact for dividends below 71041 (by 254) and 66311 (by 255)
  localparam logic [24:0] RECIP_254 = 25'd16909321;
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  // floor(v / 254), quotient must fit 8 bits
  function automatic logic [7:0] div254(input logic [15:0] v);
    logic [40:0] prod;
    prod = {25'd0, v} * {16'd0, RECIP_254};
    return prod[39:32];
  endfunction

  // floor(v / 255), quotient must fit 8 bits
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [40:0] prod;
    prod = {25'd0, v} * {16'd0, RECIP_255};
    return prod[39:32];
  endfunction

endpackage

// ===== src/hue_sat_level_to_rgb_top.sv =====
`timescale 1ns / 1ps
// hue/saturation/level to dimmed rgb converter, six register stages
// depends on hsl2rgb_pkg
// throughput: one item per cycle unless the output stalls; each stage holds its item only while the next is full
// stages: sector split, products, first /254, second /254, level scale, /255 and output
// reset: synchronous active high rst clears all stage valid bits, data is not reset

module hue_sat_level_to_rgb_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hue[7:0], saturation[15:8], level[23:16]
  input  logic [0:0]  s_axis_tuser,   // light_on[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
  import hsl2rgb_pkg::*;

  // stage enables, a stage loads when empty or when the next one loads
  logic en1, en2, en3, en4, en5, en6;
  logic vld1, vld2, vld3, vld4, vld5, vld6;

  assign en6 = !vld6 || m_axis_tready;
  assign en5 = !vld5 || en6;
  assign en4 = !vld4 || en5;
  assign en3 = !vld3 || en4;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;
  assign s_axis_tready = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
    end else begin
      if (en1) vld1 <= s_axis_tvalid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en4) vld4 <= vld3;
      if (en5) vld5 <= vld4;
      if (en6) vld6 <= vld5;
    end
  end

  // stage 1: clamp, sector and remainder of hue*6 over 254
  logic [7:0]  hue_c, sat_c, lvl_in;
  logic [10:0] scaled;
  logic [2:0]  sector_next;
  logic [10:0] rem_wide;

  assign hue_c  = (s_axis_tdata[7:0]  > HS_FULL) ? HS_FULL : s_axis_tdata[7:0];
  assign sat_c  = (s_axis_tdata[15:8] > HS_FULL) ? HS_FULL : s_axis_tdata[15:8];
  assign lvl_in = s_axis_tdata[23:16];
  assign scaled = {3'd0, hue_c} * {8'd0, SECTORS};

  always_comb begin
    if (scaled >= 11'd1524) begin
      // full-scale hue wraps to the red end
      sector_next = SEC_0;
      rem_wide    = 11'd0;
    end else if (scaled >= 11'd1270) begin
      sector_next = SEC_5;
      rem_wide    = scaled - 11'd1270;
    end else if (scaled >= 11'd1016) begin
      sector_next = SEC_4;
      rem_wide    = scaled - 11'd1016;
    end else if (scaled >= 11'd762) begin
      sector_next = SEC_3;
      rem_wide    = scaled - 11'd762;
    end else if (scaled >= 11'd508) begin
      sector_next = SEC_2;
      rem_wide    = scaled - 11'd508;
    end else if (scaled >= 11'd254) begin
      sector_next = SEC_1;
      rem_wide    = scaled - 11'd254;
    end else begin
      sector_next = SEC_0;
      rem_wide    = scaled;
    end
  end

  logic [2:0] sector1;
  logic [7:0] rem1, sat1, lvl1;
  logic       on1;

  always_ff @(posedge clk) begin
    if (en1) begin
      sector1 <= sector_next;
      rem1    <= rem_wide[7:0];
      sat1    <= sat_c;
      lvl1    <= (lvl_in == 8'd0) ? 8'd1 : lvl_in;
      on1     <= s_axis_tuser[0];
    end
  end

  // stage 2: saturation products and the p term
  logic [15:0] sr_prod, sc_prod;
  logic [7:0]  inv_sat;

  assign sr_prod = {8'd0, sat1} * {8'd0, rem1};
  assign sc_prod = {8'd0, sat1} * {8'd0, HS_FULL - rem1};
  assign inv_sat = HS_FULL - sat1;

  logic [15:0] xq2, xt2;
  logic [7:0]  p2, lvl2;
  logic [2:0]  sector2;
  logic        on2;

  always_ff @(posedge clk) begin
    if (en2) begin
      xq2     <= HS_SQ - sr_prod;
      xt2     <= HS_SQ - sc_prod;
      // 255*a/254 = a + a/254, and a/254 is one only at a = 254
      p2      <= inv_sat + {7'd0, (inv_sat == HS_FULL)};
      lvl2    <= lvl1;
      sector2 <= sector1;
      on2     <= on1;
    end
  end

  // stage 3: floor(255*x/254) = x + floor(x/254)
  logic [15:0] wq3, wt3;
  logic [7:0]  p3, lvl3;
  logic [2:0]  sector3;
  logic        on3;

  always_ff @(posedge clk) begin
    if (en3) begin
      wq3     <= xq2 + {8'd0, div254(xq2)};
      wt3     <= xt2 + {8'd0, div254(xt2)};
      p3      <= p2;
      lvl3    <= lvl2;
      sector3 <= sector2;
      on3     <= on2;
    end
  end

  // stage 4: second divide by 254 gives q and t
  logic [7:0] q4, t4, p4, lvl4;
  logic [2:0] sector4;
  logic       on4;

  always_ff @(posedge clk) begin
    if (en4) begin
      q4      <= div254(wq3);
      t4      <= div254(wt3);
      p4      <= p3;
      lvl4    <= lvl3;
      sector4 <= sector3;
      on4     <= on3;
    end
  end

  // stage 5: channel select by sector, scale by level
  logic [7:0] c_r, c_g, c_b;

  always_comb begin
    case (sector4)
      SEC_0: begin c_r = CH_FULL; c_g = t4;      c_b = p4;      end
      SEC_1: begin c_r = q4;      c_g = CH_FULL; c_b = p4;      end
      SEC_2: begin c_r = p4;      c_g = CH_FULL; c_b = t4;      end
      SEC_3: begin c_r = p4;      c_g = q4;      c_b = CH_FULL; end
      SEC_4: begin c_r = t4;      c_g = p4;      c_b = CH_FULL; end
      default: begin c_r = CH_FULL; c_g = p4;    c_b = q4;      end
    endcase
  end

  logic [15:0] pr5, pg5, pb5;
  logic        on5;

  always_ff @(posedge clk) begin
    if (en5) begin
      pr5 <= {8'd0, c_r} * {8'd0, lvl4};
      pg5 <= {8'd0, c_g} * {8'd0, lvl4};
      pb5 <= {8'd0, c_b} * {8'd0, lvl4};
      on5 <= on4;
    end
  end

  // stage 6: divide by 255, blank when off, output register
  logic [23:0] out6;

  always_ff @(posedge clk) begin
    if (en6) begin
      out6 <= on5 ? {div255(pb5), div255(pg5), div255(pr5)} : 24'd0;
    end
  end

  assign m_axis_tvalid = vld6;
  assign m_axis_tdata  = out6;

endmodule

// ===== src/hsl2rgb_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the hue/saturation/level to rgb converter
// bound to hue_sat_level_to_rgb_top, no other dependencies

module hsl2rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // empty output stage means the pipe can take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // a draining output never blocks the input
  a_ready_when_draining: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while downstream ready");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind hue_sat_level_to_rgb_top hsl2rgb_checker u_hsl2rgb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for hue_sat_level_to_rgb_top: directed corner colors, then
// random colors under four flow-control phases, with a predictor and an in-order scoreboard
// depends on hsl2rgb_pkg and hue_sat_level_to_rgb_top

module testbench;
  import hsl2rgb_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned RESET_LEN   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned PIPE_DRAIN  = 12;     // six stages plus margin
  localparam int unsigned HOLD_CYCLES = 400;    // long output hold-off
  localparam int unsigned HOLD_AFTER  = 60;     // items accepted before the hold-off
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH_IDLE
  } flow_phase_e;

  typedef struct {
    logic [7:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  level;
    logic        light_on;
    flow_phase_e phase;
  } color_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  color_item_t color_pending_q [$];
  rgb_t        rgb_expect_q [$];
  color_item_t color_in_flight;

  flow_phase_e cur_phase = PH_STEADY;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_off = 0;
  int unsigned n_dark_level = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          backoff_started = 1'b0;

  hue_sat_level_to_rgb_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // hue[7:0], saturation[15:8], level[23:16]
    .s_axis_tuser  (s_axis_tuser),   // light_on[0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // red[7:0], green[15:8], blue[23:16]
  );

  // idle and stall odds per phase, in percent
  function automatic int unsigned src_idle_pct(flow_phase_e ph);
    case (ph)
      PH_SRC_IDLE:  return 62;
      PH_BOTH_IDLE: return 29;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(flow_phase_e ph);
    case (ph)
      PH_SINK_STALL: return 62;
      PH_BOTH_IDLE:  return 29;
      default:       return 0;
    endcase
  endfunction

  // hsv construction with value at full scale, then dimmed by the level
  function automatic rgb_t hsl_to_rgb(color_item_t it);
    int unsigned hs_full, ch_full, sq;
    int unsigned h, s, k, scaled, sector, rem, p, q, t;
    int unsigned c0, c1, c2;
    rgb_t res;
    hs_full = HS_FULL;
    ch_full = CH_FULL;
    sq = hs_full * hs_full;
    h = (it.hue > HS_FULL) ? hs_full : int'(it.hue);
    s = (it.sat > HS_FULL) ? hs_full : int'(it.sat);
    k = (it.level == 8'd0) ? 1 : int'(it.level);
    res = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    if (!it.light_on)
      return res;
    scaled = h * 6;
    sector = (scaled / hs_full) % 6;
    rem = scaled % hs_full;
    p = (ch_full * (hs_full - s)) / hs_full;
    q = (ch_full * (sq - s * rem)) / sq;
    t = (ch_full * (sq - s * (hs_full - rem))) / sq;
    case (sector)
      SEC_0:   begin c0 = ch_full; c1 = t;       c2 = p;       end
      SEC_1:   begin c0 = q;       c1 = ch_full; c2 = p;       end
      SEC_2:   begin c0 = p;       c1 = ch_full; c2 = t;       end
      SEC_3:   begin c0 = p;       c1 = q;       c2 = ch_full; end
      SEC_4:   begin c0 = t;       c1 = p;       c2 = ch_full; end
      default: begin c0 = ch_full; c1 = p;       c2 = q;       end
    endcase
    res.red   = 8'((c0 * k) / ch_full);
    res.green = 8'((c1 * k) / ch_full);
    res.blue  = 8'((c2 * k) / ch_full);
    return res;
  endfunction

  task automatic push_color(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] level, input logic light_on,
                            input flow_phase_e phase);
    color_item_t it;
    it.hue = hue;
    it.sat = sat;
    it.level = level;
    it.light_on = light_on;
    it.phase = phase;
    color_pending_q.push_back(it);
  endtask

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               rgb_expect_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender: hold the item until accepted, then predict it and offer the next one
  always @(posedge clk) begin
    logic        next_valid;
    color_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        rgb_expect_q.push_back(hsl_to_rgb(color_in_flight));
        n_accepted <= n_accepted + 1;
        if (!color_in_flight.light_on)
          n_off <= n_off + 1;
        if (color_in_flight.level == 8'd0)
          n_dark_level <= n_dark_level + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && color_pending_q.size() != 0 &&
          $urandom_range(99) >= src_idle_pct(color_pending_q[0].phase)) begin
        it = color_pending_q.pop_front();
        color_in_flight = it;
        cur_phase <= it.phase;
        s_axis_tdata <= {it.level, it.sat, it.hue};
        s_axis_tuser <= it.light_on;
        next_valid = 1'b1;
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // one long hold-off so the pipeline fills and back-pressures the input
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (!backoff_started && n_accepted >= HOLD_AFTER) begin
      backoff_started <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.red   = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue  = m_axis_tdata[23:16];
        if (rgb_expect_q.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < MAX_REPORTS)
            $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        end else begin
          want = rgb_expect_q.pop_front();
          n_checked <= n_checked + 1;
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue) begin
            n_errors <= n_errors + 1;
            if (n_errors < MAX_REPORTS)
              $display("result %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       n_checked, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct(cur_phase));
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] lvl;
    int unsigned pick;

    // corner colors
    push_color(8'd0,   8'd254, 8'd255, 1'b1, PH_STEADY);   // pure red
    push_color(8'd254, 8'd254, 8'd255, 1'b1, PH_STEADY);   // hue wraps to red
    push_color(8'd255, 8'd255, 8'd255, 1'b1, PH_STEADY);   // hue and sat above range
    push_color(8'd42,  8'd254, 8'd255, 1'b1, PH_STEADY);   // end of first sector
    push_color(8'd43,  8'd254, 8'd255, 1'b1, PH_STEADY);
    push_color(8'd85,  8'd254, 8'd200, 1'b1, PH_STEADY);
    push_color(8'd127, 8'd254, 8'd255, 1'b1, PH_STEADY);   // exact sector boundary
    push_color(8'd170, 8'd200, 8'd128, 1'b1, PH_STEADY);
    push_color(8'd212, 8'd254, 8'd255, 1'b1, PH_STEADY);
    push_color(8'd253, 8'd254, 8'd255, 1'b1, PH_STEADY);
    push_color(8'd100, 8'd0,   8'd255, 1'b1, PH_STEADY);   // white
    push_color(8'd100, 8'd255, 8'd255, 1'b1, PH_STEADY);   // sat above range
    push_color(8'd100, 8'd128, 8'd0,   1'b1, PH_STEADY);   // level zero acts as one
    push_color(8'd100, 8'd128, 8'd1,   1'b1, PH_STEADY);
    push_color(8'd200, 8'd254, 8'd0,   1'b1, PH_STEADY);
    push_color(8'd30,  8'd100, 8'd255, 1'b0, PH_STEADY);   // light off
    push_color(8'd255, 8'd255, 8'd0,   1'b0, PH_STEADY);
    push_color(8'd0,   8'd0,   8'd0,   1'b1, PH_STEADY);
    push_color(8'd254, 8'd0,   8'd255, 1'b1, PH_STEADY);

    // random colors, one batch per flow-control phase
    for (int ph = 0; ph < 4; ph++) begin
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(19);
        case (pick)
          0:       lvl = 8'd0;
          1:       lvl = 8'd255;
          2:       lvl = 8'd1;
          default: lvl = 8'($urandom_range(255));
        endcase
        push_color(($urandom_range(9) == 0) ? 8'($urandom_range(255, 248))
                                            : 8'($urandom_range(254)),
                   ($urandom_range(9) == 0) ? 8'($urandom_range(255, 248))
                                            : 8'($urandom_range(254)),
                   lvl, ($urandom_range(9) != 0), flow_phase_e'(ph));
      end
    end

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    while (color_pending_q.size() != 0 || s_axis_tvalid || rgb_expect_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("checked %0d colors over four flow-control phases and one %0d-cycle hold-off",
             n_checked, HOLD_CYCLES);
    $display("%0d with the light off, %0d at level zero, %0d mismatches",
             n_off, n_dark_level, n_errors);
    if (n_errors == 0 && rgb_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
